/* rtl/psst_pkg.sv */
// Shared types and constants for the pacing strip start timer.
// Used by the channel interfaces and the top level; depends on nothing.
package psst_pkg;

  // Payload widths fixed by the poll and result formats
  localparam int unsigned TimeW     = 32;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned TabLenW   = 3;
  localparam int unsigned StripLenW = 7;
  localparam int unsigned BlinkW    = 4;
  localparam int unsigned IndexW    = 6;
  localparam int unsigned SlotW     = 2;

  // Number of delay table entries
  localparam int unsigned DelaySlots = 4;

  // Tone held on the buzzer after 50 ms past one beep period
  localparam logic [TimeW-1:0] ToneTailMs = 32'd50;

  // APB register map, one word per register
  localparam int unsigned PAddrW = 5;
  localparam int unsigned PDataW = 32;

  typedef enum logic [2:0] {
    REG_STEP_DELAY_0 = 3'd0,
    REG_STEP_DELAY_1 = 3'd1,
    REG_STEP_DELAY_2 = 3'd2,
    REG_STEP_DELAY_3 = 3'd3,
    REG_TABLE_LEN    = 3'd4,
    REG_BEEP_PERIOD  = 3'd5,
    REG_STRIP_LEN    = 3'd6,
    REG_BLINK_COUNT  = 3'd7
  } reg_e;

  // Buzzer codes
  typedef enum logic [1:0] {
    TONE_OFF  = 2'd0,
    TONE_LOW  = 2'd1,
    TONE_HIGH = 2'd2
  } tone_e;

endpackage

/* rtl/psst_in_if.sv */
// Poll channel: timestamp and button levels with a valid/ready handshake.
// Depends on psst_pkg for field widths.
interface psst_in_if;
  logic                        valid;
  logic                        ready;
  logic [psst_pkg::TimeW-1:0]  now_ms;
  logic                        start_level;
  logic                        stop_level;

  modport source (output valid, output now_ms, output start_level, output stop_level,
                  input ready);
  modport sink (input valid, input now_ms, input start_level, input stop_level,
                output ready);
endinterface

/* rtl/psst_out_if.sv */
// Result channel: lamp, buzzer, strip and elapsed-time fields with valid/ready.
// Depends on psst_pkg for field widths and the tone type.
interface psst_out_if;
  logic                        valid;
  logic                        ready;
  logic                        lamp_on;
  psst_pkg::tone_e             buzzer_tone;
  logic                        light_valid;
  logic [psst_pkg::IndexW-1:0] light_index;
  logic                        strip_clear;
  logic                        time_valid;
  logic [psst_pkg::TimeW-1:0]  elapsed_ms;

  modport source (output valid, output lamp_on, output buzzer_tone, output light_valid,
                  output light_index, output strip_clear, output time_valid,
                  output elapsed_ms, input ready);
  modport sink (input valid, input lamp_on, input buzzer_tone, input light_valid,
                input light_index, input strip_clear, input time_valid,
                input elapsed_ms, output ready);
endinterface

/* rtl/pacing_strip_start_timer.sv */
// Pacing strip start timer: one poll (timestamp plus start/stop levels) in, one result out.
// Every poll is handled combinationally: the phase logic works straight off the
// accepted poll and the state registers, and the result lands in one output register
// the cycle after the transfer. A poll can be taken every clock; in_i.ready is high
// whenever the output register is empty or its result is taken in the same cycle, so
// only a stalled result consumer slows the block. Configuration is an APB port with
// eight word registers; write it only while no poll is in flight.
// Depends on psst_pkg, psst_in_if and psst_out_if.
module pacing_strip_start_timer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  psst_in_if.sink                        in_i,
  psst_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psst_pkg::PAddrW-1:0]    paddr,
  input  logic [psst_pkg::PDataW-1:0]    pwdata,
  output logic [psst_pkg::PDataW-1:0]    prdata,
  output logic                           pready
);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_RUN   = 3'd1;
  localparam logic [2:0] PH_END   = 3'd2;
  localparam logic [2:0] PH_IDLE  = 3'd3;
  localparam logic [2:0] PH_RESET = 3'd4;

  localparam int unsigned TW = psst_pkg::TimeW;
  localparam int unsigned DW = psst_pkg::DelayW;
  localparam int unsigned SW = psst_pkg::StripLenW;

  // Configuration registers
  logic [DW-1:0]                    step_delay0_q, step_delay1_q, step_delay2_q, step_delay3_q;
  logic [psst_pkg::TabLenW-1:0]     table_len_q;
  logic [DW-1:0]                    beep_period_q;
  logic [SW-1:0]                    strip_len_q;
  logic [psst_pkg::BlinkW-1:0]      blink_count_q;

  // Phase state
  logic [2:0]                       phase_q, phase_d;
  logic                             start_lat_q, start_lat_d;
  logic                             stop_lat_q, stop_lat_d;
  logic                             beep_next_q, beep_next_d;
  logic                             lamp_q, lamp_d;
  psst_pkg::tone_e                  tone_q, tone_d;
  logic [SW-1:0]                    step_cnt_q, step_cnt_d;
  logic [psst_pkg::SlotW-1:0]       slot_q, slot_d;
  logic [TW-1:0]                    last_step_q, last_step_d;
  logic [TW-1:0]                    run_start_q, run_start_d;
  logic [TW-1:0]                    beep_time_q, beep_time_d;
  logic [TW-1:0]                    stop_time_q, stop_time_d;

  // Result register
  logic                             out_valid_q;
  logic                             res_light_valid_q, res_light_valid_d;
  logic [psst_pkg::IndexW-1:0]      res_light_index_q, res_light_index_d;
  logic                             res_strip_clear_q, res_strip_clear_d;
  logic                             res_time_valid_q, res_time_valid_d;
  logic [TW-1:0]                    res_elapsed_q, res_elapsed_d;

  logic                             in_fire;
  logic                             cfg_wr;
  psst_pkg::reg_e                   cfg_sel;
  logic [DW-1:0]                    cur_delay;
  logic                             step_due;
  logic [TW-1:0]                    since_beep;
  logic [TW-1:0]                    tone_limit;
  logic [psst_pkg::TabLenW-1:0]     eff_len;
  logic [psst_pkg::TabLenW-1:0]     slot_next;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // APB access
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = psst_pkg::reg_e'(paddr[psst_pkg::PAddrW-1:2]);

  always_comb begin
    case (cfg_sel)
      psst_pkg::REG_STEP_DELAY_0: prdata = {16'd0, step_delay0_q};
      psst_pkg::REG_STEP_DELAY_1: prdata = {16'd0, step_delay1_q};
      psst_pkg::REG_STEP_DELAY_2: prdata = {16'd0, step_delay2_q};
      psst_pkg::REG_STEP_DELAY_3: prdata = {16'd0, step_delay3_q};
      psst_pkg::REG_TABLE_LEN:    prdata = {29'd0, table_len_q};
      psst_pkg::REG_BEEP_PERIOD:  prdata = {16'd0, beep_period_q};
      psst_pkg::REG_STRIP_LEN:    prdata = {25'd0, strip_len_q};
      psst_pkg::REG_BLINK_COUNT:  prdata = {28'd0, blink_count_q};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_delay0_q <= 16'd100;
      step_delay1_q <= 16'd100;
      step_delay2_q <= 16'd100;
      step_delay3_q <= 16'd100;
      table_len_q   <= 3'd2;
      beep_period_q <= 16'd500;
      strip_len_q   <= 7'd20;
      blink_count_q <= 4'd3;
    end else if (cfg_wr) begin
      case (cfg_sel)
        psst_pkg::REG_STEP_DELAY_0: step_delay0_q <= pwdata[DW-1:0];
        psst_pkg::REG_STEP_DELAY_1: step_delay1_q <= pwdata[DW-1:0];
        psst_pkg::REG_STEP_DELAY_2: step_delay2_q <= pwdata[DW-1:0];
        psst_pkg::REG_STEP_DELAY_3: step_delay3_q <= pwdata[DW-1:0];
        psst_pkg::REG_TABLE_LEN:    table_len_q   <= pwdata[psst_pkg::TabLenW-1:0];
        psst_pkg::REG_BEEP_PERIOD:  beep_period_q <= pwdata[DW-1:0];
        psst_pkg::REG_STRIP_LEN:    strip_len_q   <= pwdata[SW-1:0];
        psst_pkg::REG_BLINK_COUNT:  blink_count_q <= pwdata[psst_pkg::BlinkW-1:0];
        default: ;
      endcase
    end
  end

  // Pick the current step delay and test the step and tone timers
  always_comb begin
    case (slot_q)
      2'd0:    cur_delay = step_delay0_q;
      2'd1:    cur_delay = step_delay1_q;
      2'd2:    cur_delay = step_delay2_q;
      default: cur_delay = step_delay3_q;
    endcase
  end

  assign step_due   = in_i.now_ms > (last_step_q + {16'd0, cur_delay});
  assign since_beep = in_i.now_ms - beep_time_q;
  assign tone_limit = {16'd0, beep_period_q} + psst_pkg::ToneTailMs;

  // Clamp the table length to 1..DelaySlots
  always_comb begin
    if (table_len_q == '0) begin
      eff_len = 3'd1;
    end else if (table_len_q > 3'(psst_pkg::DelaySlots)) begin
      eff_len = 3'(psst_pkg::DelaySlots);
    end else begin
      eff_len = table_len_q;
    end
  end

  assign slot_next = {1'b0, slot_q} + 3'd1;

  // Phase logic for one poll
  always_comb begin
    phase_d     = phase_q;
    start_lat_d = start_lat_q;
    stop_lat_d  = stop_lat_q;
    beep_next_d = beep_next_q;
    lamp_d      = lamp_q;
    tone_d      = tone_q;
    step_cnt_d  = step_cnt_q;
    slot_d      = slot_q;
    last_step_d = last_step_q;
    run_start_d = run_start_q;
    beep_time_d = beep_time_q;
    stop_time_d = stop_time_q;

    res_light_valid_d = 1'b0;
    res_light_index_d = '0;
    res_strip_clear_d = 1'b0;
    res_time_valid_d  = 1'b0;
    res_elapsed_d     = '0;

    // Latch the buttons and the stop press time
    if (in_i.start_level) begin
      start_lat_d = 1'b1;
    end
    if (in_i.stop_level) begin
      stop_lat_d  = 1'b1;
      stop_time_d = in_i.now_ms;
    end

    case (phase_q)
      PH_START: begin
        if (since_beep > {16'd0, beep_period_q}) begin
          beep_time_d = in_i.now_ms;
          if (beep_next_q) begin
            lamp_d      = 1'b1;
            tone_d      = psst_pkg::TONE_LOW;
            beep_next_d = 1'b0;
          end else begin
            lamp_d      = 1'b0;
            tone_d      = psst_pkg::TONE_OFF;
            beep_next_d = 1'b1;
          end
          step_cnt_d = step_cnt_q + 7'd1;
        end
        // Go signal after more than twice the blink count toggles
        if (step_cnt_d > {2'b00, blink_count_q, 1'b0}) begin
          lamp_d      = 1'b1;
          tone_d      = psst_pkg::TONE_HIGH;
          run_start_d = in_i.now_ms;
          step_cnt_d  = '0;
          beep_next_d = 1'b0;
          phase_d     = PH_RUN;
          start_lat_d = 1'b0;
        end
      end
      PH_RUN: begin
        if (step_due) begin
          slot_d            = (slot_next >= eff_len) ? '0 : slot_next[psst_pkg::SlotW-1:0];
          last_step_d       = in_i.now_ms;
          res_light_valid_d = 1'b1;
          res_light_index_d = step_cnt_q[psst_pkg::IndexW-1:0];
          step_cnt_d        = step_cnt_q + 7'd1;
        end
        // Silence the tone once the tail has passed
        if (since_beep > tone_limit && !beep_next_q) begin
          lamp_d      = 1'b0;
          tone_d      = psst_pkg::TONE_OFF;
          beep_next_d = 1'b1;
        end
        if (step_cnt_d == strip_len_q) begin
          phase_d = PH_END;
        end
      end
      PH_END: begin
        if (step_due) begin
          res_strip_clear_d = 1'b1;
        end
        if (stop_lat_d && step_due) begin
          phase_d          = PH_RESET;
          res_time_valid_d = 1'b1;
          res_elapsed_d    = stop_time_d - run_start_q;
        end
        if (start_lat_d) begin
          phase_d = PH_RESET;
        end
      end
      PH_IDLE: begin
        if (start_lat_d) begin
          start_lat_d = 1'b0;
          phase_d     = PH_START;
        end
      end
      default: begin
        // Reset phase and unused codes: clear the strip and rearm
        res_strip_clear_d = 1'b1;
        stop_lat_d        = 1'b0;
        start_lat_d       = 1'b0;
        slot_d            = '0;
        last_step_d       = '0;
        beep_time_d       = '0;
        step_cnt_d        = '0;
        beep_next_d       = 1'b1;
        phase_d           = PH_IDLE;
      end
    endcase
  end

  // Advance the state on each poll transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_RESET;
      start_lat_q <= 1'b0;
      stop_lat_q  <= 1'b0;
      beep_next_q <= 1'b0;
      lamp_q      <= 1'b0;
      tone_q      <= psst_pkg::TONE_OFF;
      step_cnt_q  <= '0;
      slot_q      <= '0;
      last_step_q <= '0;
      run_start_q <= '0;
      beep_time_q <= '0;
      stop_time_q <= '0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      start_lat_q <= start_lat_d;
      stop_lat_q  <= stop_lat_d;
      beep_next_q <= beep_next_d;
      lamp_q      <= lamp_d;
      tone_q      <= tone_d;
      step_cnt_q  <= step_cnt_d;
      slot_q      <= slot_d;
      last_step_q <= last_step_d;
      run_start_q <= run_start_d;
      beep_time_q <= beep_time_d;
      stop_time_q <= stop_time_d;
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_light_valid_q <= res_light_valid_d;
      res_light_index_q <= res_light_index_d;
      res_strip_clear_q <= res_strip_clear_d;
      res_time_valid_q  <= res_time_valid_d;
      res_elapsed_q     <= res_elapsed_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.lamp_on     = lamp_q;
  assign out_o.buzzer_tone = tone_q;
  assign out_o.light_valid = res_light_valid_q;
  assign out_o.light_index = res_light_index_q;
  assign out_o.strip_clear = res_strip_clear_q;
  assign out_o.time_valid  = res_time_valid_q;
  assign out_o.elapsed_ms  = res_elapsed_q;

`ifndef ASSERT_OFF
  // A strip LED is never lit in the same result that clears the strip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_light_valid_q && res_strip_clear_q))
    else $error("light and clear in one result");

  // A time report always comes with a strip clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_time_valid_q) |-> res_strip_clear_q)
    else $error("time report without strip clear");

  // The reset phase always hands over to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PH_RESET) |=> phase_q == PH_IDLE)
    else $error("reset phase did not move to idle");

  // An empty result register never blocks a poll
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("poll blocked with empty result register");

  // A phase leaves for run only through start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_d == PH_RUN) |-> (phase_q == PH_START || phase_q == PH_RUN))
    else $error("run entered from wrong phase");
`endif

endmodule
